/* rtl/cttr_pkg.sv */
`timescale 1ns / 1ps
package cttr_pkg;

	localparam int TABLE_DEPTH_DEF   = 64;
	localparam int MAX_PAYLOAD_BYTES = 8;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 64;
	localparam int SLOT_W            = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_DLC_FILTER   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_WINDOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANGED_ONLY = 3'd4;

	localparam logic CMD_FRAME = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	localparam logic [23:0] RATE_SCALE = 24'd10000000;

	typedef struct packed {
		logic [28:0] ident;
		logic [3:0]  len;
		logic [63:0] bytes;
		logic [63:0] first_time;
		logic [63:0] prev_time;
		logic [63:0] last_time;
		logic [31:0] count;
		logic        ever_changed;
		logic        range_ok;
		logic [7:0]  range_max;
		logic [7:0]  range_min;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic        is_new;
		logic        data_changed;
		logic [31:0] frame_count;
		logic [63:0] delta_us;
		logic [31:0] rate_tenths;
		logic        stats_valid;
		logic        range_valid;
		logic [7:0]  first_byte_min;
		logic [7:0]  first_byte_max;
		logic        hidden;
		logic        table_full;
	} result_t;

	// mask of the payload bytes that count for a given length
	function automatic logic [63:0] byte_mask(input logic [3:0] len);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < MAX_PAYLOAD_BYTES; b++) begin
			if (len > 4'(b)) m[8*b +: 8] = 8'hff;
		end
		return m;
	endfunction

endpackage

/* rtl/cttr_ram.sv */
`timescale 1ns / 1ps
module cttr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

/* rtl/cttr_div.sv */
`timescale 1ns / 1ps
module cttr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);

	logic [64:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] dsr_q;
	logic [6:0]  cnt_q;
	logic        done_q;
	logic [64:0] rem_sh;
	logic        ge;

	// one quotient bit per cycle, restoring
	always_comb begin
		rem_sh = {rem_q[63:0], quo_q[63]};
		ge     = rem_sh >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 7'd64;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/can_id_traffic_tracker_top.sv */
`timescale 1ns / 1ps
// an accepted item runs through the identifier scan and the table update, then through the
// rate divider when the entry already held a frame and its elapsed time is nonzero
// the block takes one item at a time; the table scan (one memory read a cycle), the
// bit-serial 64-bit divider and a stalled result item all hold in_stall high
// reset: arst_n clears the control state, the config registers and all table valid bits
module can_id_traffic_tracker_top
	import cttr_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration port
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_wdata,
	// input item channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    cmd,
	input  logic [28:0]             frame_id,
	input  logic [3:0]              frame_len,
	input  logic [63:0]             payload,
	input  logic [63:0]             frame_time,
	// result item channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [SLOT_W-1:0]       slot,
	output logic                    is_new,
	output logic                    data_changed,
	output logic [31:0]             frame_count,
	output logic [63:0]             delta_us,
	output logic [31:0]             rate_tenths,
	output logic                    stats_valid,
	output logic                    range_valid,
	output logic [7:0]              first_byte_min,
	output logic [7:0]              first_byte_max,
	output logic                    hidden,
	output logic                    table_full
);

	localparam int AW = $clog2(TABLE_DEPTH);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SCAN   = 7'b0000010,
		ST_UPD    = 7'b0000100,
		ST_MUL    = 7'b0001000,
		ST_DSTART = 7'b0010000,
		ST_DWAIT  = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [3:0]  dlc_filter_q;
	logic        use_window_q;
	logic [63:0] win_start_q;
	logic [63:0] win_end_q;
	logic        changed_only_q;

	// captured frame
	logic [28:0] id_q;
	logic [3:0]  len_q;
	logic [63:0] data_q;
	logic [63:0] ts_q;

	// scan bookkeeping
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [AW:0]            issue_q;
	logic                   cmp_q;
	logic [AW-1:0]          cmp_idx_q;
	logic                   hit_q;
	logic [AW-1:0]          hit_idx_q;
	logic                   free_found_q;
	logic [AW-1:0]          free_idx_q;
	entry_t                 ent_q;

	// arithmetic
	logic [63:0] elapsed_q;
	logic [55:0] prod_q;
	logic [63:0] div_q;
	logic        div_done;

	// result staging and output register
	result_t         res_q;
	logic [AW-1:0]   res_slot_q;
	result_t         out_q;
	logic [AW-1:0]   out_slot_q;
	logic            out_valid_q;

	entry_t        rd_entry;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_entry;

	logic accept;
	logic filtered;
	logic out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// length filter and optional time window
	always_comb begin
		filtered = 1'b0;
		if (dlc_filter_q != 4'd0 && frame_len != dlc_filter_q) filtered = 1'b1;
		if (use_window_q) begin
			if (frame_time < win_start_q) filtered = 1'b1;
			if (win_end_q != 64'd0 && frame_time > win_end_q) filtered = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dlc_filter_q   <= '0;
			use_window_q   <= 1'b0;
			win_start_q    <= '0;
			win_end_q      <= '0;
			changed_only_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DLC_FILTER:   dlc_filter_q   <= cfg_wdata[3:0];
				CFG_USE_WINDOW:   use_window_q   <= cfg_wdata[0];
				CFG_WINDOW_START: win_start_q    <= cfg_wdata;
				CFG_WINDOW_END:   win_end_q      <= cfg_wdata;
				CFG_CHANGED_ONLY: changed_only_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// table memory, read one entry per cycle during the scan
	assign rd_addr = issue_q[AW-1:0];

	cttr_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_entry),
		.raddr (rd_addr),
		.rdata (rd_entry)
	);

	// update of the entry and the result fields
	logic        upd_full;
	logic        upd_new;
	logic        upd_changed;
	logic [63:0] upd_mask;
	logic [7:0]  b0;
	entry_t      base;
	result_t     upd_res;
	logic [63:0] upd_elapsed;

	always_comb begin
		upd_full    = !hit_q && !free_found_q;
		upd_new     = !hit_q;
		upd_mask    = byte_mask(len_q);
		b0          = data_q[7:0];
		wr_addr     = hit_q ? hit_idx_q : free_idx_q;
		upd_changed = 1'b0;
		base        = ent_q;
		if (upd_new) begin
			base.ident        = id_q;
			base.len          = len_q;
			base.bytes        = data_q;
			base.first_time   = ts_q;
			base.prev_time    = ts_q;
			base.last_time    = ts_q;
			base.count        = 32'd1;
			base.ever_changed = 1'b0;
			base.range_ok     = 1'b0;
			base.range_max    = '0;
			base.range_min    = '0;
		end else begin
			upd_changed = (len_q != ent_q.len) || (data_q != (ent_q.bytes & upd_mask));
			if (upd_changed) begin
				base.ever_changed = 1'b1;
				base.len          = len_q;
				base.bytes        = data_q;
			end
			base.prev_time = ent_q.last_time;
			base.last_time = ts_q;
			if (ent_q.count != 32'hffff_ffff) base.count = ent_q.count + 32'd1;
		end
		// byte 0 range from frames that carry a byte 0
		if (len_q != 4'd0) begin
			if (!base.range_ok) begin
				base.range_ok  = 1'b1;
				base.range_min = b0;
				base.range_max = b0;
			end else begin
				if (b0 < base.range_min) base.range_min = b0;
				if (b0 > base.range_max) base.range_max = b0;
			end
		end
		wr_entry    = base;
		wr_en       = (state_q == ST_UPD) && !upd_full;
		upd_elapsed = base.last_time - base.first_time;

		upd_res = '0;
		if (upd_full) begin
			upd_res.table_full = 1'b1;
		end else begin
			upd_res.is_new       = upd_new;
			upd_res.data_changed = upd_changed;
			upd_res.frame_count  = base.count;
			upd_res.stats_valid  = !upd_new;
			upd_res.range_valid  = !upd_new && len_q != 4'd0;
			if (!upd_new) upd_res.delta_us = base.last_time - base.prev_time;
			if (upd_res.range_valid) begin
				upd_res.first_byte_min = base.range_min;
				upd_res.first_byte_max = base.range_max;
			end
			upd_res.hidden = changed_only_q && !base.ever_changed;
		end
	end

	// rate divider: (count - 1) * 1e7 + elapsed / 2, over elapsed
	logic        div_start;
	logic [63:0] div_dividend;

	assign div_start    = (state_q == ST_DSTART);
	assign div_dividend = {8'd0, prod_q} + {1'b0, elapsed_q[63:1]};

	cttr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (elapsed_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			issue_q      <= '0;
			cmp_q        <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd == CMD_CLEAR) begin
							valid_q <= '0;
						end else if (!filtered) begin
							state_q      <= ST_SCAN;
							issue_q      <= '0;
							cmp_q        <= 1'b0;
							hit_q        <= 1'b0;
							free_found_q <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (issue_q < (AW+1)'(TABLE_DEPTH)) begin
						issue_q <= issue_q + 1'b1;
						cmp_q   <= 1'b1;
					end else begin
						cmp_q <= 1'b0;
					end
					if (cmp_q) begin
						if (valid_q[cmp_idx_q] && rd_entry.ident == id_q) begin
							hit_q   <= 1'b1;
							state_q <= ST_UPD;
						end else begin
							if (!valid_q[cmp_idx_q] && !free_found_q) free_found_q <= 1'b1;
							if (cmp_idx_q == AW'(TABLE_DEPTH - 1)) state_q <= ST_UPD;
						end
					end
				end
				ST_UPD: begin
					if (wr_en) valid_q[wr_addr] <= 1'b1;
					if (upd_full || upd_new || upd_elapsed == 64'd0) state_q <= ST_DONE;
					else state_q <= ST_MUL;
				end
				ST_MUL:    state_q <= ST_DSTART;
				ST_DSTART: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (div_done) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q   <= frame_id;
			len_q  <= frame_len;
			data_q <= payload & byte_mask(frame_len);
			ts_q   <= frame_time;
		end
		if (state_q == ST_SCAN) begin
			cmp_idx_q <= issue_q[AW-1:0];
			if (cmp_q) begin
				if (valid_q[cmp_idx_q] && rd_entry.ident == id_q) begin
					hit_idx_q <= cmp_idx_q;
					ent_q     <= rd_entry;
				end else if (!valid_q[cmp_idx_q] && !free_found_q) begin
					free_idx_q <= cmp_idx_q;
				end
			end
		end
		if (state_q == ST_UPD) begin
			res_q      <= upd_res;
			res_slot_q <= upd_full ? '0 : wr_addr;
			elapsed_q  <= upd_elapsed;
		end
		if (state_q == ST_MUL) begin
			prod_q <= (res_q.frame_count - 32'd1) * RATE_SCALE;
		end
		if (state_q == ST_DWAIT && div_done) begin
			res_q.rate_tenths <= (div_q[63:32] != 32'd0) ? 32'hffff_ffff : div_q[31:0];
		end
		if (state_q == ST_DONE && out_free) begin
			out_q      <= res_q;
			out_slot_q <= res_slot_q;
		end
	end

	logic [AW+SLOT_W-1:0] slot_wide;
	assign slot_wide = {{SLOT_W{1'b0}}, out_slot_q};

	assign out_valid      = out_valid_q;
	assign slot           = slot_wide[SLOT_W-1:0];
	assign is_new         = out_q.is_new;
	assign data_changed   = out_q.data_changed;
	assign frame_count    = out_q.frame_count;
	assign delta_us       = out_q.delta_us;
	assign rate_tenths    = out_q.rate_tenths;
	assign stats_valid    = out_q.stats_valid;
	assign range_valid    = out_q.range_valid;
	assign first_byte_min = out_q.first_byte_min;
	assign first_byte_max = out_q.first_byte_max;
	assign hidden         = out_q.hidden;
	assign table_full     = out_q.table_full;

endmodule
